[hdl/gb2312_glyph_address_stream_top_defines.svh]
// Assertion macros shared by the glyph address stream RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef GB2312_GLYPH_ADDRESS_STREAM_TOP_DEFINES_SVH
`define GB2312_GLYPH_ADDRESS_STREAM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GGA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("gga check failed");
`define GGA_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("gga forbidden condition");
`else
`define GGA_ASSERT(lbl, clk, rst_n, prop)
`define GGA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[hdl/gga_pkg.sv]
// Types and constants for the GB2312 glyph address stream.
// No dependencies; imported by every module of the block.
`default_nettype none
package gga_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_START_PAGE   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_COLUMN = 1'b1;

	localparam logic [3:0] RESET_PAGE   = 4'd1;
	localparam logic [7:0] RESET_COLUMN = 8'd1;

	localparam logic [7:0] HIGH_LIMIT  = 8'hA0;
	localparam logic [7:0] FIRST_CELL  = 8'hA1;
	localparam logic [7:0] SYM_LAST    = 8'hA3;
	localparam logic [7:0] ZONE_A9     = 8'hA9;
	localparam logic [7:0] HANZI_FIRST = 8'hB0;
	localparam logic [7:0] HANZI_LAST  = 8'hF7;
	localparam logic [7:0] ASCII_FIRST = 8'h20;
	localparam logic [7:0] ASCII_LAST  = 8'h7E;

	localparam logic [6:0]  ROW_LEN    = 7'd94;
	localparam logic [9:0]  A9_BASE    = 10'd282;
	localparam logic [9:0]  HANZI_BASE = 10'd846;
	localparam logic [17:0] ASCII_BASE = 18'h3B7C0;

	localparam logic [7:0] WIDE_STEP   = 8'd16;
	localparam logic [7:0] NARROW_STEP = 8'd8;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} gga_in_t;

	typedef struct packed {
		logic [17:0] glyph_address;
		logic        wide_glyph;
		logic [3:0]  draw_page;
		logic [7:0]  draw_column;
		logic        code_valid;
		logic        last_glyph;
	} gga_out_t;

	typedef struct packed {
		logic [7:0] high_byte;
		logic [7:0] low_byte;
		logic       wide;
		logic [3:0] page;
		logic [7:0] column;
		logic       last;
	} gga_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} gga_q_status_t;

endpackage
`default_nettype wire

[hdl/gga_front.sv]
// Front end: byte acceptance, double-byte pairing, column tracking and config registers.
// Depends on gga_pkg; pushes glyph jobs into gga_queue.
`default_nettype none
module gga_front
	import gga_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire gga_in_t                in_data,
	output logic                        in_stall,
	input  wire logic                   cfg_valid,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                        cfg_ready,
	input  wire gga_q_status_t          q_status,
	output logic                        push,
	output gga_job_t                    push_job
);

	logic [3:0] page_q;
	logic [7:0] start_col_q;
	logic [7:0] col_q;
	logic [7:0] hb_q;
	logic       pending_q;
	logic       accept;
	logic       is_high;

	assign in_stall  = q_status.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign is_high   = in_data.text_byte > HIGH_LIMIT;

	always_comb begin
		push              = 1'b0;
		push_job.page     = page_q;
		push_job.column   = col_q;
		push_job.last     = in_data.last_byte;
		push_job.high_byte = 8'd0;
		push_job.low_byte = in_data.text_byte;
		push_job.wide     = 1'b0;
		if (accept) begin
			if (pending_q) begin
				push               = 1'b1;
				push_job.high_byte = hb_q;
				push_job.wide      = 1'b1;
			end else if (is_high) begin
				push               = in_data.last_byte;
				push_job.high_byte = in_data.text_byte;
				push_job.low_byte  = 8'd0;
				push_job.wide      = 1'b1;
			end else begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q      <= RESET_PAGE;
			start_col_q <= RESET_COLUMN;
			col_q       <= RESET_COLUMN;
			hb_q        <= 8'd0;
			pending_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_PAGE: page_q <= cfg_data[3:0];
					CFG_START_COLUMN: begin
						start_col_q <= cfg_data;
						col_q       <= cfg_data;
					end
					default: ;
				endcase
			end
			if (accept) begin
				if (pending_q) begin
					pending_q <= 1'b0;
					hb_q      <= 8'd0;
				end else if (is_high && !in_data.last_byte) begin
					pending_q <= 1'b1;
					hb_q      <= in_data.text_byte;
				end
			end
			if (push) begin
				if (push_job.last) begin
					col_q <= start_col_q;
				end else begin
					col_q <= col_q + (push_job.wide ? WIDE_STEP : NARROW_STEP);
				end
			end
		end
	end

endmodule
`default_nettype wire

[hdl/gga_queue.sv]
// Two-entry job queue between the front end and the address back end.
// Depends on gga_pkg and the assertion macro header.
`default_nettype none
`include "gb2312_glyph_address_stream_top_defines.svh"
module gga_queue
	import gga_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire gga_job_t push_job,
	input  wire logic     pop,
	output gga_job_t      head,
	output gga_q_status_t status
);

	gga_job_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = count_q == 2'd2;
	assign status.empty = count_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	`GGA_NEVER(a_no_push_full, clk, arst_n, push && status.full && !pop)
	`GGA_NEVER(a_no_pop_empty, clk, arst_n, pop && status.empty)
	`GGA_NEVER(a_count_bound, clk, arst_n, count_q == 2'd3)
	`GGA_ASSERT(a_fill, clk, arst_n, (push && !pop && count_q == 2'd1) |=> status.full)

endmodule
`default_nettype wire

[hdl/gga_back.sv]
// Back end: GB2312 zone and ASCII address mapping into the output register.
// Depends on gga_pkg; pops jobs from gga_queue.
`default_nettype none
module gga_back
	import gga_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire gga_job_t      head,
	input  wire gga_q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output gga_out_t           out_data
);

	logic        out_valid_q;
	gga_out_t    out_q;
	logic        load;
	logic        dbl;
	logic        zone_ok;
	logic [6:0]  row;
	logic [9:0]  base;
	logic [7:0]  lb_off;
	logic [12:0] idx;
	logic [6:0]  ascii_off;
	gga_out_t    nxt;

	assign load      = !out_valid_q || !out_stall;
	assign pop       = load && !q_status.empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		dbl       = (head.high_byte > HIGH_LIMIT) && (head.low_byte > HIGH_LIMIT);
		lb_off    = head.low_byte - FIRST_CELL;
		row       = 7'd0;
		base      = 10'd0;
		zone_ok   = 1'b0;
		ascii_off = 7'(head.low_byte - ASCII_FIRST);
		if (head.high_byte == ZONE_A9) begin
			base    = A9_BASE;
			zone_ok = 1'b1;
		end else if (head.high_byte inside {[FIRST_CELL:SYM_LAST]}) begin
			row     = 7'(head.high_byte - FIRST_CELL);
			zone_ok = 1'b1;
		end else if (head.high_byte inside {[HANZI_FIRST:HANZI_LAST]}) begin
			row     = 7'(head.high_byte - HANZI_FIRST);
			base    = HANZI_BASE;
			zone_ok = 1'b1;
		end
		idx = 13'(13'(row) * 13'(ROW_LEN)) + 13'(lb_off) + 13'(base);

		nxt.wide_glyph    = head.wide;
		nxt.draw_page     = head.page;
		nxt.draw_column   = head.column;
		nxt.last_glyph    = head.last;
		nxt.glyph_address = 18'd0;
		nxt.code_valid    = 1'b0;
		if (dbl) begin
			if (zone_ok) begin
				nxt.glyph_address = {idx, 5'd0};
				nxt.code_valid    = 1'b1;
			end
		end else if (head.low_byte inside {[ASCII_FIRST:ASCII_LAST]}) begin
			nxt.glyph_address = ASCII_BASE + {7'd0, ascii_off, 4'd0};
			nxt.code_valid    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_status.empty;
		end
	end

endmodule
`default_nettype wire

[hdl/gb2312_glyph_address_stream_top.sv]
// GB2312 glyph address stream: text bytes in, font ROM glyph fetch requests out.
// Depends on gga_pkg, gga_front, gga_queue and gga_back.
//
// Usage:
//   in channel  (in_valid/in_stall/in_data): one raw string byte per transfer,
//     last_byte marks the end of the string.
//   out channel (out_valid/out_stall/out_data): one glyph request per character;
//     a GB2312 high byte produces nothing until its low byte arrives, unless it carries last_byte.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): start_page and
//     start_column; cfg_ready is always high. Write only while the block is idle.
//     Writing start_column also reloads the running column.
// Throughput: one byte per cycle while in_stall is low, set by the combinational pairing logic in the
//   front end and the combinational zone multiply-add in the back end.
// Path: the completing byte of a glyph writes its job into the queue, and the job is then
//   loaded into the output register once that register is free to take it.
// Reset: page 1, start column 1, no high byte held, queue and output empty.
// Stall: the two-entry queue absorbs back pressure; in_stall rises when it is
//   full, and the output holds its transfer while out_stall is high.
`default_nettype none
module gb2312_glyph_address_stream_top
	import gga_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire gga_in_t                in_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output gga_out_t                    out_data,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	gga_q_status_t q_status;
	gga_job_t      push_job;
	gga_job_t      head;
	logic          push;
	logic          pop;

	gga_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.q_status  (q_status),
		.push      (push),
		.push_job  (push_job)
	);

	gga_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	gga_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

[bench/gb2312_glyph_address_stream_top_tb.sv]
// Self-checking bench for the GB2312 glyph address stream top level.
// Needs gga_pkg and the RTL below gb2312_glyph_address_stream_top; a ledger
// class predicts each glyph request from the accepted text bytes.
`default_nettype none

import gga_pkg::*;

class glyph_ledger;
	logic [3:0] page_reg;
	logic [7:0] column_reg;
	logic [7:0] column_now;
	logic [7:0] held_high;
	logic       high_waiting;
	gga_out_t   glyphs_due[$];
	int         mismatches;

	function new();
		page_reg     = RESET_PAGE;
		column_reg   = RESET_COLUMN;
		column_now   = RESET_COLUMN;
		held_high    = 8'd0;
		high_waiting = 1'b0;
		mismatches   = 0;
	endfunction

	task report(input string msg);
		if (mismatches < 40) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	function int due_count();
		return glyphs_due.size();
	endfunction

	function logic [17:0] rom_address(input logic [7:0] hb, input logic [7:0] lb,
			output logic mapped);
		int h;
		int l;
		int addr;
		h = int'(hb);
		l = int'(lb);
		addr = 0;
		mapped = 1'b1;
		if (hb > HIGH_LIMIT && lb > HIGH_LIMIT) begin
			if (hb == ZONE_A9) begin
				addr = (int'(A9_BASE) + l - int'(FIRST_CELL)) * 32;
			end else if (hb >= FIRST_CELL && hb <= SYM_LAST) begin
				addr = ((h - int'(FIRST_CELL)) * int'(ROW_LEN) + l - int'(FIRST_CELL)) * 32;
			end else if (hb >= HANZI_FIRST && hb <= HANZI_LAST) begin
				addr = ((h - int'(HANZI_FIRST)) * int'(ROW_LEN) + l - int'(FIRST_CELL)
					+ int'(HANZI_BASE)) * 32;
			end else begin
				mapped = 1'b0;
			end
		end else if (lb >= ASCII_FIRST && lb <= ASCII_LAST) begin
			addr = (l - int'(ASCII_FIRST)) * 16 + int'(ASCII_BASE);
		end else begin
			mapped = 1'b0;
		end
		return addr[17:0];
	endfunction

	function void queue_glyph(input logic [7:0] hb, input logic [7:0] lb,
			input logic wide, input logic last);
		gga_out_t g;
		logic     mapped;
		g.glyph_address = rom_address(hb, lb, mapped);
		g.wide_glyph    = wide;
		g.draw_page     = page_reg;
		g.draw_column   = column_now;
		g.code_valid    = mapped;
		g.last_glyph    = last;
		glyphs_due.push_back(g);
		if (last) begin
			column_now = column_reg;
		end else begin
			column_now = column_now + (wide ? WIDE_STEP : NARROW_STEP);
		end
	endfunction

	function void set_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		if (index == CFG_START_PAGE) begin
			page_reg = data[3:0];
		end else if (index == CFG_START_COLUMN) begin
			column_reg = data;
			column_now = data;
		end
	endfunction

	function void note_byte(input gga_in_t d);
		logic [7:0] hb;
		if (high_waiting) begin
			hb = held_high;
			high_waiting = 1'b0;
			held_high = 8'd0;
			queue_glyph(hb, d.text_byte, 1'b1, d.last_byte);
		end else if (d.text_byte > HIGH_LIMIT) begin
			if (d.last_byte) begin
				queue_glyph(d.text_byte, 8'd0, 1'b1, 1'b1);
			end else begin
				held_high = d.text_byte;
				high_waiting = 1'b1;
			end
		end else begin
			queue_glyph(8'd0, d.text_byte, 1'b0, d.last_byte);
		end
	endfunction

	task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s got %0h want %0h", name, got, want));
		end
	endtask

	task check_glyph(input gga_out_t got);
		gga_out_t want;
		if (glyphs_due.size() == 0) begin
			report($sformatf("unexpected glyph transfer %0h", got));
		end else begin
			want = glyphs_due.pop_front();
			compare_field("glyph_address", 32'(got.glyph_address),
				32'(want.glyph_address));
			compare_field("wide_glyph", 32'(got.wide_glyph), 32'(want.wide_glyph));
			compare_field("draw_page", 32'(got.draw_page), 32'(want.draw_page));
			compare_field("draw_column", 32'(got.draw_column), 32'(want.draw_column));
			compare_field("code_valid", 32'(got.code_valid), 32'(want.code_valid));
			compare_field("last_glyph", 32'(got.last_glyph), 32'(want.last_glyph));
		end
	endtask
endclass

module gb2312_glyph_address_stream_top_tb;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	gga_in_t                in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	gga_out_t               out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	glyph_ledger ledger;
	bit          in_gaps_on = 1'b0;
	bit          out_stalls_on = 1'b0;
	int          sent = 0;
	int          stall_left = 0;

	gb2312_glyph_address_stream_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		logic hold;
		hold = 1'b0;
		if (stall_left != 0) begin
			stall_left--;
			hold = 1'b1;
		end else if (out_stalls_on && $urandom_range(99) < 8) begin
			stall_left = $urandom_range(4);
			hold = 1'b1;
		end
		out_stall <= hold;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				ledger.set_register(cfg_index, cfg_data);
			end
			if (in_valid && !in_stall) begin
				ledger.note_byte(in_data);
			end
			if (out_valid && !out_stall) begin
				ledger.check_glyph(out_data);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (in_gaps_on && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{text_byte: b, last_byte: last};
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (ledger.due_count() != 0) @(posedge clk);
	endtask

	task automatic send_string(input int n);
		int         k;
		int         pick;
		logic       end_here;
		logic [7:0] hb;
		logic [7:0] lb;
		for (k = 0; k < n; k++) begin
			end_here = (k == n - 1);
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_byte(8'($urandom_range(8'h7E, 8'h20)), end_here);
			end else if (pick < 80) begin
				case ($urandom_range(9))
					0: hb = ZONE_A9;
					1, 2: hb = 8'($urandom_range(SYM_LAST, FIRST_CELL));
					3: hb = 8'($urandom_range(8'hFF, 8'hA1));
					default: hb = 8'($urandom_range(HANZI_LAST, HANZI_FIRST));
				endcase
				if ($urandom_range(99) < 85) begin
					lb = 8'($urandom_range(8'hFE, FIRST_CELL));
				end else begin
					lb = 8'($urandom_range(255));
				end
				send_byte(hb, 1'b0);
				send_byte(lb, end_here);
			end else if (pick < 88) begin
				send_byte(8'($urandom_range(8'hFF, 8'hA1)), end_here);
			end else begin
				send_byte(8'($urandom_range(255)), end_here);
			end
		end
	endtask

	initial begin
		logic [8:0] opening[25];
		logic [3:0] page_set;
		logic [7:0] col_set;
		int         phase;
		int         target;
		bit         paused;
		opening = '{
			{8'h20, 1'b0}, {8'h7E, 1'b0}, {8'h1F, 1'b0}, {8'h7F, 1'b0}, {8'h00, 1'b0},
			{8'hA1, 1'b0}, {8'hA1, 1'b0}, {8'hA3, 1'b0}, {8'hFE, 1'b0},
			{8'hA9, 1'b0}, {8'hA1, 1'b0}, {8'hB0, 1'b0}, {8'hA1, 1'b0},
			{8'hF7, 1'b0}, {8'hFE, 1'b0}, {8'hA4, 1'b0}, {8'hA1, 1'b0},
			{8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hA1, 1'b0}, {8'h41, 1'b0},
			{8'hB0, 1'b0}, {8'h10, 1'b1}, {8'hF7, 1'b1}, {8'h41, 1'b1}
		};
		paused = 1'b0;
		ledger = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
		foreach (opening[i]) begin
			send_byte(opening[i][8:1], opening[i][0]);
		end
		drain();
		repeat (4) @(posedge clk);

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					page_set = 4'd8;
					col_set = 8'd128;
				end
				1: begin
					page_set = 4'd1;
					col_set = 8'd1;
				end
				default: begin
					page_set = 4'($urandom_range(8, 1));
					col_set = 8'($urandom_range(128, 1));
				end
			endcase
			in_gaps_on = (phase != 2);
			out_stalls_on = (phase != 2);
			if ($urandom_range(1)) begin
				write_reg(CFG_START_PAGE, {4'd0, page_set});
				write_reg(CFG_START_COLUMN, col_set);
			end else begin
				write_reg(CFG_START_COLUMN, col_set);
				write_reg(CFG_START_PAGE, {4'd0, page_set});
			end
			target = sent + 145;
			while (sent < target) begin
				if (phase == 3 && !paused && sent >= target - 80) begin
					drain();
					paused = 1'b1;
				end
				send_string($urandom_range(24, 1));
			end
			drain();
			repeat (4) @(posedge clk);
		end

		repeat (10) @(posedge clk);
		if (ledger.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
